>>> hdl/gwps_pkg.sv
// Package for the grid word path search block.
// Holds the op codes, controller states, config indices, directions and the command/status structs.
package gwps_pkg;

  typedef enum logic [1:0] {
    OP_GRID   = 2'd0,
    OP_WORD   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_START_RD,
    ST_START_CMP,
    ST_TOP,
    ST_NB_RD,
    ST_NB_CMP,
    ST_POP,
    ST_NEXT_START,
    ST_DONE
  } state_t;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_WLEN = 2'd2;

  localparam int unsigned DIR_UP    = 0;
  localparam int unsigned DIR_LEFT  = 1;
  localparam int unsigned DIR_DOWN  = 2;
  localparam int unsigned DIR_RIGHT = 3;

  typedef struct packed {
    logic load;       // store the input beat
    logic init;       // reset search position and clear pointer
    logic clr_step;   // clear one visited mark
    logic rd_start;   // read grid at start cell and word[0]
    logic push_first; // push start cell
    logic nb_step;    // evaluate top frame direction, issue neighbour read
    logic push;       // push neighbour
    logic pop;        // pop top frame
    logic adv_start;  // move to the next start cell
    logic finish;     // drive the result strobe
    logic result;     // found value
  } ctl_t;

  typedef struct packed {
    logic len_zero;
    logic len_one;
    logic area_empty;
    logic clr_done;
    logic start_match;
    logic start_last;
    logic depth_zero;
    logic top_dir_done;
    logic nb_valid;
    logic nb_match;
    logic nb_last;
  } sts_t;

endpackage

>>> hdl/grid_word_path_search.sv
// Top level of the grid word path search: controller plus datapath.
// Uses gwps_pkg, gwps_ctrl, gwps_datapath.
//
//  channel | signals                                   | handshake
//  input   | op cell_row cell_col word_pos char_value  | start && !busy
//  config  | cfg_index cfg_data                        | cfg_valid && cfg_ready
//  result  | found                                     | done, one cycle
//
// A grid or word write gives no beat. A search with an empty word or an empty area goes
// straight to the done state. Otherwise each start cell is read, compared and moved past,
// each neighbour tried passes the top, read and compare states, each pop the top and pop
// states, and the first matching start cell of a search adds the visited-mark clearing.
// The result beat comes in the cycle after the search ends; busy drops with it.
// Reset clears the configuration to one row, one column, one character; results never stall.
module grid_word_path_search #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8,
  parameter int MAX_WORD = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [2:0] cell_row,
  input  logic [2:0] cell_col,
  input  logic [3:0] word_pos,
  input  logic [7:0] char_value,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  output logic       done,
  output logic       found
);
  import gwps_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  gwps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op), .sts(sts), .ctl(ctl),
    .busy(busy), .done(done)
  );

  gwps_datapath #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_WORD(MAX_WORD)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op(op), .cell_row(cell_row), .cell_col(cell_col), .word_pos(word_pos),
    .char_value(char_value), .found(found)
  );
endmodule

>>> hdl/gwps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gwps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/gwps_datapath.sv
// Datapath of the grid word path search: grid, word and visited memories,
// the path stack, the search position and the config registers. Uses gwps_pkg, gwps_ram.
module gwps_datapath #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8,
  parameter int MAX_WORD = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  gwps_pkg::ctl_t    ctl,
  output gwps_pkg::sts_t    sts,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [4:0]        cfg_data,
  input  logic [1:0]        op,
  input  logic [2:0]        cell_row,
  input  logic [2:0]        cell_col,
  input  logic [3:0]        word_pos,
  input  logic [7:0]        char_value,
  output logic              found
);
  import gwps_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NCELL = MAX_ROWS * MAX_COLS;
  localparam int AW = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int WW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int DW = $clog2(MAX_WORD + 1);
  localparam int FW = RW + CW + 3;

  logic [3:0] rows_in_use;
  logic [3:0] cols_in_use;
  logic [4:0] word_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 4'd1;
      cols_in_use <= 4'd1;
      word_length <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS: rows_in_use <= cfg_data[3:0];
        CFG_COLS: cols_in_use <= cfg_data[3:0];
        CFG_WLEN: word_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated dimensions.
  logic [6:0] nr;
  logic [6:0] nc;
  logic [6:0] len;
  assign nr  = (7'(rows_in_use) > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : 7'(rows_in_use);
  assign nc  = (7'(cols_in_use) > 7'(MAX_COLS)) ? 7'(MAX_COLS) : 7'(cols_in_use);
  assign len = (7'(word_length) > 7'(MAX_WORD)) ? 7'(MAX_WORD) : 7'(word_length);

  // Start position.
  logic [RW-1:0] sr;
  logic [CW-1:0] sc;
  logic [AW:0]   clr_cnt;

  // Stack: row, col, direction per frame.
  logic [FW-1:0] stk [MAX_WORD];
  logic [DW-1:0] depth;

  logic [FW-1:0] top;
  logic [RW-1:0] t_r;
  logic [CW-1:0] t_c;
  logic [2:0]    t_d;
  assign top = stk[WW'(depth - DW'(1))];
  assign t_r = top[FW-1 -: RW];
  assign t_c = top[CW+2 -: CW];
  assign t_d = top[2:0];

  // Neighbour of the top frame.
  logic          nb_ok;
  logic [RW-1:0] n_r;
  logic [CW-1:0] n_c;
  always_comb begin
    nb_ok = 1'b0;
    n_r = t_r;
    n_c = t_c;
    case (t_d[1:0])
      2'(DIR_UP): begin
        nb_ok = (t_r != '0);
        n_r = t_r - RW'(1);
      end
      2'(DIR_LEFT): begin
        nb_ok = (t_c != '0);
        n_c = t_c - CW'(1);
      end
      2'(DIR_DOWN): begin
        nb_ok = (7'(t_r) + 7'd1 < nr);
        n_r = t_r + RW'(1);
      end
      default: begin
        nb_ok = (7'(t_c) + 7'd1 < nc);
        n_c = t_c + CW'(1);
      end
    endcase
  end

  logic [RW-1:0] h_r;
  logic [CW-1:0] h_c;

  // Grid memory.
  logic          g_we;
  logic [AW-1:0] g_waddr;
  logic [AW-1:0] g_raddr;
  logic [7:0]    g_rdata;
  assign g_we = ctl.load && (op == OP_GRID) && (7'(cell_row) < 7'(MAX_ROWS))
                && (7'(cell_col) < 7'(MAX_COLS));
  assign g_waddr = AW'(32'(cell_row) * MAX_COLS + 32'(cell_col));
  assign g_raddr = ctl.rd_start ? AW'(32'(sr) * MAX_COLS + 32'(sc))
                                : AW'(32'(n_r) * MAX_COLS + 32'(n_c));

  gwps_ram #(.WIDTH(8), .DEPTH(NCELL)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(char_value),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  // Word memory.
  logic          w_we;
  logic [WW-1:0] w_raddr;
  logic [7:0]    w_rdata;
  assign w_we = ctl.load && (op == OP_WORD) && (7'(word_pos) < 7'(MAX_WORD));
  assign w_raddr = ctl.rd_start ? '0 : WW'(depth);

  gwps_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_word (
    .clk(clk), .we(w_we), .waddr(WW'(word_pos)), .wdata(char_value),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  // Visited marks, one flag per cell, each read by address.
  logic [NCELL-1:0] visited;
  logic             vis_q;
  logic [AW-1:0]    pop_addr;
  assign pop_addr = AW'(32'(t_r) * MAX_COLS + 32'(t_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
    end else if (ctl.clr_step) begin
      visited[AW'(clr_cnt)] <= 1'b0;
    end else if (ctl.push_first) begin
      visited[AW'(32'(sr) * MAX_COLS + 32'(sc))] <= 1'b1;
    end else if (ctl.push) begin
      visited[AW'(32'(h_r) * MAX_COLS + 32'(h_c))] <= 1'b1;
    end else if (ctl.pop) begin
      visited[pop_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.nb_step) begin
      vis_q <= visited[g_raddr];
      h_r <= n_r;
      h_c <= n_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sr <= '0;
      sc <= '0;
      clr_cnt <= '0;
      depth <= '0;
    end else begin
      if (ctl.init) begin
        sr <= '0;
        sc <= '0;
        clr_cnt <= '0;
      end else if (ctl.adv_start) begin
        if (7'(sc) + 7'd1 >= nc) begin
          sc <= '0;
          sr <= sr + RW'(1);
        end else begin
          sc <= sc + CW'(1);
        end
      end
      if (ctl.clr_step) begin
        clr_cnt <= clr_cnt + (AW+1)'(1);
      end
      if (ctl.push_first) begin
        stk[0] <= {sr, sc, 3'd0};
        depth <= DW'(1);
      end else if (ctl.push) begin
        stk[WW'(depth)] <= {h_r, h_c, 3'd0};
        depth <= depth + DW'(1);
      end else if (ctl.pop) begin
        depth <= depth - DW'(1);
      end
      if (ctl.nb_step) begin
        stk[WW'(depth - DW'(1))] <= {t_r, t_c, t_d + 3'd1};
      end
      if (ctl.finish) begin
        depth <= '0;
      end
    end
  end

  logic nb_valid_q;
  always_ff @(posedge clk) begin
    if (ctl.nb_step) begin
      nb_valid_q <= nb_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.finish) begin
      found <= ctl.result;
    end
  end

  assign sts.len_zero     = (len == 7'd0);
  assign sts.len_one      = (len == 7'd1);
  assign sts.area_empty   = (nr == 7'd0) || (nc == 7'd0);
  assign sts.clr_done     = (clr_cnt == (AW+1)'(NCELL));
  assign sts.start_match  = (g_rdata == w_rdata);
  assign sts.start_last   = (7'(sr) + 7'd1 >= nr) && (7'(sc) + 7'd1 >= nc);
  assign sts.depth_zero   = (depth == '0);
  assign sts.top_dir_done = t_d[2];
  assign sts.nb_valid     = nb_valid_q;
  assign sts.nb_match     = !vis_q && (g_rdata == w_rdata);
  assign sts.nb_last      = (7'(depth) + 7'd1 == len);

  property p_depth_bound;
    @(posedge clk) disable iff (rst) 7'(depth) <= len;
  endproperty
  a_depth_bound: assert property (p_depth_bound) else $error("stack depth beyond word");

  property p_push_grows;
    @(posedge clk) disable iff (rst) ctl.push |=> depth == $past(depth) + DW'(1);
  endproperty
  a_push_grows: assert property (p_push_grows) else $error("push did not grow stack");

  property p_no_pop_empty;
    @(posedge clk) disable iff (rst) ctl.pop |-> depth != '0;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop on empty stack");
endmodule

>>> hdl/gwps_ctrl.sv
// Controller state machine of the grid word path search.
// Uses gwps_pkg; drives the datapath by command struct.
module gwps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     op,
  input  gwps_pkg::sts_t sts,
  output gwps_pkg::ctl_t ctl,
  output logic           busy,
  output logic           done
);
  import gwps_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && op == OP_SEARCH) begin
          if (sts.len_zero || sts.area_empty) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_START_RD;
          end
        end
      end
      ST_START_RD: state_next = ST_START_CMP;
      ST_START_CMP: begin
        if (!sts.start_match) begin
          state_next = ST_NEXT_START;
        end else if (sts.len_one) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (sts.clr_done) begin
          state_next = ST_TOP;
        end
      end
      ST_TOP: begin
        if (sts.depth_zero) begin
          state_next = ST_NEXT_START;
        end else if (sts.top_dir_done) begin
          state_next = ST_POP;
        end else begin
          state_next = ST_NB_RD;
        end
      end
      ST_NB_RD: state_next = ST_NB_CMP;
      ST_NB_CMP: begin
        if (sts.nb_valid && sts.nb_match && sts.nb_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_TOP;
        end
      end
      ST_POP: state_next = ST_TOP;
      ST_NEXT_START: begin
        if (sts.start_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_START_RD;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        ctl.load = accept;
        ctl.init = accept;
      end
      ST_START_RD: ctl.rd_start = 1'b1;
      ST_START_CMP: begin
        if (sts.start_match && sts.len_one) begin
          ctl.finish = 1'b1;
          ctl.result = 1'b1;
        end
      end
      ST_CLEAR: begin
        ctl.clr_step = !sts.clr_done;
        ctl.push_first = sts.clr_done;
      end
      ST_TOP: begin
        ctl.pop = !sts.depth_zero && sts.top_dir_done;
      end
      ST_NB_RD: ctl.nb_step = 1'b1;
      ST_NB_CMP: begin
        if (sts.nb_valid && sts.nb_match) begin
          if (sts.nb_last) begin
            ctl.finish = 1'b1;
            ctl.result = 1'b1;
          end else begin
            ctl.push = 1'b1;
          end
        end
      end
      ST_NEXT_START: begin
        ctl.adv_start = 1'b1;
        ctl.init = 1'b0;
        if (sts.start_last) begin
          ctl.finish = 1'b1;
        end
      end
      ST_DONE: begin
        ctl.finish = 1'b1;
        ctl.result = sts.len_zero;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("result without search");

  property p_finish_ends;
    @(posedge clk) disable iff (rst) ctl.finish |=> state == ST_IDLE;
  endproperty
  a_finish_ends: assert property (p_finish_ends) else $error("search did not end");

  property p_one_cmd;
    @(posedge clk) disable iff (rst) $onehot0({ctl.push, ctl.pop, ctl.push_first});
  endproperty
  a_one_cmd: assert property (p_one_cmd) else $error("conflicting stack commands");
endmodule

>>> tb/sv/grid_word_path_search_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the grid word path search block.
// Depends on gwps_pkg and grid_word_path_search; predicts every search locally.
module grid_word_path_search_tb;
  import gwps_pkg::*;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] op;
  logic [2:0] cell_row;
  logic [2:0] cell_col;
  logic [3:0] word_pos;
  logic [7:0] char_value;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  logic       done;
  logic       found;

  grid_word_path_search dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .cell_row(cell_row), .cell_col(cell_col), .word_pos(word_pos),
    .char_value(char_value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .found(found)
  );

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] idx;
    logic [4:0] data;
    op_t        cmd;
    logic [2:0] r;
    logic [2:0] c;
    logic [3:0] p;
    logic [7:0] ch;
    bit         typed;
    bit         typed_found;
  } stim_row_t;

  logic [7:0] grid_mem [64];
  logic [7:0] word_mem [16];
  logic [3:0] rows_cfg;
  logic [3:0] cols_cfg;
  logic [4:0] wlen_cfg;

  bit        found_q [$];
  stim_row_t stim_tbl [$];
  int        mismatches;
  int        searches_sent;
  int        items_sent;
  int        results_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Timeout: run did not complete.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit word_on_grid();
    int nr, nc, len, r, c, sp, cur, nxt, rr, cc, st;
    bit ok;
    int stc [16];
    int sdir [16];
    bit vis [64];
    nr = (rows_cfg > 8) ? 8 : rows_cfg;
    nc = (cols_cfg > 8) ? 8 : cols_cfg;
    len = (wlen_cfg > 16) ? 16 : wlen_cfg;
    if (len == 0) return 1'b1;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        st = r * 8 + c;
        if (grid_mem[st] != word_mem[0]) continue;
        if (len == 1) return 1'b1;
        foreach (vis[i]) vis[i] = 1'b0;
        vis[st] = 1'b1;
        stc[0] = st;
        sdir[0] = 0;
        sp = 1;
        while (sp > 0) begin
          cur = stc[sp-1];
          if (sdir[sp-1] >= 4) begin
            vis[cur] = 1'b0;
            sp--;
            continue;
          end
          rr = cur / 8;
          cc = cur % 8;
          ok = 1'b1;
          case (sdir[sp-1])
            DIR_UP: begin
              if (rr == 0) ok = 1'b0; else rr--;
            end
            DIR_LEFT: begin
              if (cc == 0) ok = 1'b0; else cc--;
            end
            DIR_DOWN: begin
              if (rr + 1 >= nr) ok = 1'b0; else rr++;
            end
            default: begin
              if (cc + 1 >= nc) ok = 1'b0; else cc++;
            end
          endcase
          sdir[sp-1]++;
          if (!ok) continue;
          nxt = rr * 8 + cc;
          if (vis[nxt] || grid_mem[nxt] != word_mem[sp]) continue;
          if (sp + 1 == len) return 1'b1;
          vis[nxt] = 1'b1;
          stc[sp] = nxt;
          sdir[sp] = 0;
          sp++;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ROWS: rows_cfg = data[3:0];
      CFG_COLS: cols_cfg = data[3:0];
      CFG_WLEN: wlen_cfg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_cmd(input op_t cmd, input logic [2:0] r, input logic [2:0] c,
                          input logic [3:0] p, input logic [7:0] ch,
                          input bit typed, input bit typed_found);
    int gap;
    bit pred;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    op         <= cmd;
    cell_row   <= r;
    cell_col   <= c;
    word_pos   <= p;
    char_value <= ch;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    case (cmd)
      OP_GRID: grid_mem[{r, c}] = ch;
      OP_WORD: word_mem[p] = ch;
      OP_SEARCH: begin
        pred = word_on_grid();
        if (typed && pred != typed_found)
          $display("Note: typed expectation %0b differs from prediction %0b",
                   typed_found, pred);
        found_q.push_back(typed ? typed_found : pred);
        searches_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (found_q.size() > 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [4:0] data);
    stim_row_t s;
    s = '{kind: ROW_CFG, idx: idx, data: data, cmd: OP_NONE, r: 0, c: 0, p: 0,
          ch: 0, typed: 0, typed_found: 0};
    stim_tbl.push_back(s);
  endtask

  task automatic add_cmd(input op_t cmd, input logic [2:0] r, input logic [2:0] c,
                         input logic [3:0] p, input logic [7:0] ch,
                         input bit typed, input bit typed_found);
    stim_row_t s;
    s = '{kind: ROW_ITEM, idx: 0, data: 0, cmd: cmd, r: r, c: c, p: p, ch: ch,
          typed: typed, typed_found: typed_found};
    stim_tbl.push_back(s);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (found_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: found=%0b", found);
      end else begin
        if (found !== found_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on found: expected %0b, got %0b", found_q[0], found);
        end
        void'(found_q.pop_front());
      end
    end
  end

  initial begin
    int n, nitems, k;
    bit small_mode;
    int nr, nc, len;
    op_t cmd;
    logic [7:0] ch;
    mismatches = 0;
    searches_sent = 0;
    items_sent = 0;
    results_seen = 0;
    rows_cfg = 4'd1;
    cols_cfg = 4'd1;
    wlen_cfg = 5'd1;
    rst <= 1'b1;
    start <= 1'b0;
    op <= OP_NONE;
    cell_row <= '0;
    cell_col <= '0;
    word_pos <= '0;
    char_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ROWS;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every grid cell and word character gets a known value before any search.
    for (int i = 0; i < 64; i++)
      send_cmd(OP_GRID, 3'(i / 8), 3'(i % 8), 4'd0, 8'(8'h40 + i), 1'b0, 1'b0);
    for (int i = 0; i < 16; i++)
      send_cmd(OP_WORD, 3'd0, 3'd0, 4'(i), 8'(8'h80 + i), 1'b0, 1'b0);
    settle();

    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b0);
    add_cfg(CFG_WLEN, 5'd0);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b1);
    add_cfg(CFG_WLEN, 5'd1);
    add_cfg(CFG_ROWS, 5'd0);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b0);
    add_cfg(CFG_ROWS, 5'd1);
    add_cfg(CFG_COLS, 5'd0);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b0);
    add_cfg(CFG_COLS, 5'd1);
    add_cmd(OP_GRID, 0, 0, 0, 8'h00, 0, 0);
    add_cmd(OP_WORD, 0, 0, 0, 8'h00, 0, 0);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b1);
    add_cmd(OP_WORD, 0, 0, 0, 8'hFF, 0, 0);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b0);
    add_cmd(OP_GRID, 0, 0, 0, 8'hFF, 0, 0);
    add_cmd(OP_NONE, 7, 7, 15, 8'h00, 0, 0);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b1);
    add_cfg(CFG_ROWS, 5'd15);
    add_cfg(CFG_COLS, 5'd15);
    add_cfg(CFG_WLEN, 5'd31);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b0);
    add_cfg(CFG_WLEN, 5'd2);
    add_cmd(OP_WORD, 0, 0, 0, 8'h7F, 0, 0);
    add_cmd(OP_WORD, 0, 0, 1, 8'h7E, 0, 0);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_WORD, 0, 0, 1, 8'hFF, 0, 0);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 0, 0);
    add_cfg(CFG_WLEN, 5'd3);
    add_cmd(OP_WORD, 0, 0, 0, 8'h7E, 0, 0);
    add_cmd(OP_WORD, 0, 0, 1, 8'h7F, 0, 0);
    add_cmd(OP_WORD, 0, 0, 2, 8'h7E, 0, 0);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b0);
    add_cfg(CFG_WLEN, 5'd16);
    add_cmd(OP_SEARCH, 0, 0, 0, 0, 1, 1'b0);

    foreach (stim_tbl[i]) begin
      if (stim_tbl[i].kind == ROW_CFG) begin
        settle();
        write_reg(stim_tbl[i].idx, stim_tbl[i].data);
      end else begin
        send_cmd(stim_tbl[i].cmd, stim_tbl[i].r, stim_tbl[i].c, stim_tbl[i].p,
                 stim_tbl[i].ch, stim_tbl[i].typed, stim_tbl[i].typed_found);
      end
    end
    settle();

    n = 0;
    while (n < 40) begin
      small_mode = ($urandom_range(0, 3) != 0);
      if (small_mode) begin
        write_reg(CFG_ROWS, 5'($urandom_range(1, 3)));
        write_reg(CFG_COLS, 5'($urandom_range(1, 3)));
        write_reg(CFG_WLEN, ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom_range(1, 6)));
      end else begin
        write_reg(CFG_ROWS, 5'($urandom_range(0, 15)));
        write_reg(CFG_COLS, 5'($urandom_range(0, 15)));
        write_reg(CFG_WLEN, 5'($urandom_range(0, 31)));
      end
      nr = (rows_cfg > 8) ? 8 : rows_cfg;
      nc = (cols_cfg > 8) ? 8 : cols_cfg;
      len = (wlen_cfg > 16) ? 16 : wlen_cfg;
      nitems = $urandom_range(8, 20);
      for (int j = 0; j < nitems; j++) begin
        k = $urandom_range(0, 99);
        cmd = (k < 40) ? OP_GRID : (k < 65) ? OP_WORD : (k < 95) ? OP_SEARCH : OP_NONE;
        if (small_mode && $urandom_range(0, 4) != 0) ch = 8'(8'h41 + $urandom_range(0, 1));
        else ch = 8'($urandom_range(0, 255));
        if (small_mode)
          send_cmd(cmd, 3'($urandom_range(0, (nr > 0) ? nr - 1 : 0)),
                   3'($urandom_range(0, (nc > 0) ? nc - 1 : 0)),
                   4'($urandom_range(0, (len > 0) ? len - 1 : 0)), ch, 1'b0, 1'b0);
        else
          send_cmd(cmd, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   4'($urandom_range(0, 15)), ch, 1'b0, 1'b0);
        if (cmd != OP_NONE) n++;
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d accepted items, %0d searches and %0d result beats,",
             items_sent, searches_sent, results_seen);
    $display("over degenerate, saturated, small and full grid sizes.");
    if (mismatches == 0 && found_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatches, found_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
